>>> hdl/humidity_sensor_dew_monitor_core_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the dew monitor core
// Concurrent assertion shorthands used by the checker file.
// ---------------------------------------------------------------------------
`ifndef HUMIDITY_SENSOR_DEW_MONITOR_CORE_MACROS_SVH
`define HUMIDITY_SENSOR_DEW_MONITOR_CORE_MACROS_SVH

// Assertion sampled on the rising clock edge, switched off while reset is low.
`define HSDM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion that stays live through reset.
`define HSDM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/hsdm_pkg.sv
// ---------------------------------------------------------------------------
// Dew monitor package
// Shared constants, types and a helper function.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package hsdm_pkg;

    localparam int unsigned DIV_N_W = 36;
    localparam int unsigned DIV_D_W = 32;

    localparam logic [31:0] LN2_Q32       = 32'hB17217F8;
    localparam logic [31:0] HUM_SCALE     = 32'd10000;
    localparam logic [31:0] TEMP_SCALE    = 32'd20000;
    localparam logic [31:0] TERM_GAIN     = 32'd1155072;
    localparam logic [31:0] MAGNUS_B      = 32'd24304;
    localparam logic [31:0] SECS_PER_HOUR = 32'd3600;
    localparam logic [31:0] SECS_PER_MIN  = 32'd60;
    localparam logic [31:0] RATE_MIN_DT   = 32'd60;
    localparam logic [13:0] LN_REF_X      = 14'd10000;
    localparam logic [4:0]  LOG_TOP_EXP   = 5'd30;
    localparam logic [3:0]  STATUS_BUSY_BIT = 4'd7;

    typedef struct packed {
        logic                 start;
        logic [DIV_N_W-1:0]   dividend;
        logic [DIV_D_W-1:0]   divisor;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [DIV_N_W-1:0]   quotient;
    } div_rsp_t;

    // Index of the highest set bit; zero for zero.
    function automatic logic [3:0] msb_index(input logic [13:0] x);
        logic [3:0] k;
        k = 4'd0;
        for (int i = 0; i < 14; i++) begin
            if (x[i]) begin
                k = 4'(i);
            end
        end
        return k;
    endfunction

endpackage

>>> hdl/hsdm_mul.sv
// ---------------------------------------------------------------------------
// Shared multiplier
// Unsigned 32 by 32 multiply with a registered product.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module hsdm_mul import hsdm_pkg::*; (
    input  logic        aclk,
    input  logic [31:0] op_a,
    input  logic [31:0] op_b,
    output logic [63:0] product
);

    logic [63:0] product_reg;

    always_ff @(posedge aclk) begin
        product_reg <= 64'(op_a) * 64'(op_b);
    end

    assign product = product_reg;

endmodule

>>> hdl/hsdm_div.sv
// ---------------------------------------------------------------------------
// Shared divider
// Restoring unsigned divider, one quotient bit per clock.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module hsdm_div import hsdm_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [DIV_N_W-1:0] quo_reg;
    logic [DIV_D_W-1:0] rem_reg;
    logic [DIV_D_W-1:0] den_reg;
    logic [5:0]         cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [DIV_D_W:0]   trial;
    logic               fits;

    assign trial = {rem_reg, quo_reg[DIV_N_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'(DIV_N_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            den_reg <= req.divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[DIV_N_W-2:0], fits};
            rem_reg <= fits ? DIV_D_W'(trial - {1'b0, den_reg}) : trial[DIV_D_W-1:0];
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

>>> hdl/humidity_sensor_dew_monitor_core.sv
// ---------------------------------------------------------------------------
// Humidity sensor dew monitor core
// Sensor frame in, temperature, humidity, dew point and condensation outlook out.
// ---------------------------------------------------------------------------
// One beat on the slave side carries a six-byte sensor frame and a seconds
// timestamp; one beat on the master side carries the answer. A frame marked
// busy yields an all-zero beat with m_tuser low. A usable frame needs two
// natural logarithms of sixteen squaring steps each (a square on the shared
// multiplier, then a normalisation) and two to four divisions on the shared
// serial divider, each a launch, the iteration and a hand-back, all ordered
// by a one-hot sequencer. The countdown division runs only when the spread
// is at least 2 C and the block is cooling, and the rate division only when
// 60 s or more have passed since the last rate update. s_tready is high only
// while the sequencer is idle; the finished beat sits in an output register,
// so a new frame is taken while the previous answer still waits for m_tready.
`timescale 1ns / 1ps

module humidity_sensor_dew_monitor_core import hsdm_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    // Frame input; tdata from bit 0: status_byte, frame_byte1..frame_byte5,
    // now_seconds (80 bits).
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,
    // Result; tdata from bit 0: temperature_centi, humidity_centi,
    // dew_point_centi, condensation_risk, countdown_minutes, zero padding.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,
    // tuser: accepted.
    output logic        m_tuser,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [19:0] {
        S_IDLE  = 20'h00001,
        S_HUM   = 20'h00002,
        S_TMP   = 20'h00004,
        S_TFIX  = 20'h00008,
        S_LSQ   = 20'h00010,
        S_LNORM = 20'h00020,
        S_LLN   = 20'h00040,
        S_LRES  = 20'h00080,
        S_TDIV  = 20'h00100,
        S_TWAIT = 20'h00200,
        S_AMUL  = 20'h00400,
        S_DDIV  = 20'h00800,
        S_DWAIT = 20'h01000,
        S_CMUL  = 20'h02000,
        S_CDIV  = 20'h04000,
        S_CWAIT = 20'h08000,
        S_RMUL  = 20'h10000,
        S_RDIV  = 20'h20000,
        S_RWAIT = 20'h40000,
        S_FIN   = 20'h80000
    } state_t;

    state_t state_reg, state_next;

    // Configuration.
    logic signed [10:0] offset_reg;

    // Frame capture and intermediate results.
    logic [19:0]        raw_h_reg, raw_t_reg;
    logic [31:0]        now_reg;
    logic               busy_frame_reg;
    logic [13:0]        hum_reg;
    logic signed [14:0] temp_reg;
    logic [31:0]        m_reg;
    logic [3:0]         lg_int_reg;
    logic [15:0]        lg_frac_reg;
    logic [3:0]         bit_reg;
    logic               pass_reg;
    logic [19:0]        ln_h_reg, ln_ref_reg;
    logic signed [21:0] alpha_reg;
    logic signed [14:0] dew_reg;
    logic signed [16:0] spread_reg;
    logic signed [16:0] cd_reg;

    // State kept between frames.
    logic               have_reg;
    logic signed [14:0] last_temp_reg;
    logic [31:0]        last_time_reg;
    logic signed [31:0] rate_reg;

    // Output register.
    logic               out_valid_reg;
    logic [63:0]        out_data_reg;
    logic               out_user_reg;

    // Shared units.
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    div_req_t    div_req;
    div_rsp_t    div_rsp;

    hsdm_mul u_mul (
        .aclk    (aclk),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .product (mul_p)
    );

    hsdm_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    logic               s_beat;
    logic               out_free;
    logic [34:0]        round_sum;
    logic signed [16:0] t_sum;
    logic signed [14:0] t_clamp;
    logic [13:0]        log_x;
    logic [3:0]         log_k;
    logic [31:0]        log_m;
    logic [31:0]        sq;
    logic [51:0]        ln_sum;
    logic [19:0]        ln_w;
    logic [13:0]        temp_mag;
    logic signed [16:0] term_den;
    logic [20:0]        q_term;
    logic signed [21:0] term_s;
    logic signed [21:0] ln_diff;
    logic [20:0]        alpha_mag;
    logic signed [22:0] mag_den;
    logic signed [14:0] dew_w;
    logic signed [16:0] spread_w;
    logic [31:0]        rate_mag;
    logic signed [15:0] diff;
    logic [15:0]        diff_mag;
    logic [31:0]        dt;

    assign s_beat   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    // Rounded scaling of the raw 20-bit fields.
    assign round_sum = mul_p[34:0] + 35'h0_0008_0000;
    assign t_sum     = $signed({2'b00, round_sum[34:20]}) - 17'sd5000
                     + $signed({{6{offset_reg[10]}}, offset_reg});
    always_comb begin
        if (t_sum < -17'sd6000) begin
            t_clamp = -15'sd6000;
        end else if (t_sum > 17'sd16000) begin
            t_clamp = 15'sd16000;
        end else begin
            t_clamp = t_sum[14:0];
        end
    end

    // Logarithm set-up: mantissa normalised so its top bit sits at bit 30.
    assign log_x  = (state_reg == S_TFIX) ? ((hum_reg == 14'd0) ? 14'd1 : hum_reg)
                                          : LN_REF_X;
    assign log_k  = msb_index(log_x);
    assign log_m  = {18'd0, log_x} << (LOG_TOP_EXP - {1'b0, log_k});
    assign sq     = mul_p[61:30];
    assign ln_sum = mul_p[51:0] + 52'h0_0000_8000_0000;
    assign ln_w   = ln_sum[51:32];

    // Magnus term and dew point helpers.
    assign temp_mag = temp_reg[14] ? 14'(-temp_reg) : temp_reg[13:0];
    assign term_den = 17'sd24304 + $signed({{2{temp_reg[14]}}, temp_reg});
    assign q_term   = div_rsp.quotient[20:0];
    assign term_s   = temp_reg[14] ? -$signed({1'b0, q_term}) : $signed({1'b0, q_term});
    assign ln_diff  = $signed({2'b00, ln_h_reg}) - $signed({2'b00, ln_ref_reg});
    assign alpha_mag = alpha_reg[21] ? 21'(-alpha_reg) : alpha_reg[20:0];
    assign mag_den  = 23'sd1155072 - $signed({alpha_reg[21], alpha_reg});

    always_comb begin
        if (mag_den <= 23'sd0) begin
            dew_w = 15'sd16000;
        end else if (alpha_reg[21]) begin
            dew_w = (div_rsp.quotient > 36'd10000) ? -15'sd10000
                                                   : -$signed(div_rsp.quotient[14:0]);
        end else begin
            dew_w = (div_rsp.quotient > 36'd16000) ? 15'sd16000
                                                   : $signed(div_rsp.quotient[14:0]);
        end
    end

    assign spread_w = $signed({{2{temp_reg[14]}}, temp_reg})
                    - $signed({{2{dew_w[14]}}, dew_w});
    assign rate_mag = 32'(-rate_reg);
    assign diff     = $signed({temp_reg[14], temp_reg})
                    - $signed({last_temp_reg[14], last_temp_reg});
    assign diff_mag = diff[15] ? 16'(-diff) : diff;
    assign dt       = now_reg - last_time_reg;

    // Operands of the shared multiplier; the product appears in the next cycle.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_HUM: begin
                mul_a = 32'(raw_h_reg);
                mul_b = HUM_SCALE;
            end
            S_TMP: begin
                mul_a = 32'(raw_t_reg);
                mul_b = TEMP_SCALE;
            end
            S_LSQ: begin
                mul_a = m_reg;
                mul_b = m_reg;
            end
            S_LLN: begin
                mul_a = {12'd0, lg_int_reg, lg_frac_reg};
                mul_b = LN2_Q32;
            end
            S_LRES: begin
                mul_a = 32'(temp_mag);
                mul_b = TERM_GAIN;
            end
            S_TWAIT, S_AMUL: begin
                mul_a = 32'(alpha_mag);
                mul_b = MAGNUS_B;
            end
            S_CMUL: begin
                mul_a = 32'(spread_reg - 17'sd200);
                mul_b = SECS_PER_MIN;
            end
            S_RMUL: begin
                mul_a = 32'(diff_mag);
                mul_b = SECS_PER_HOUR;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Divider requests; rounding half-divisor added except for the countdown.
    always_comb begin
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;
        unique case (state_reg)
            S_TDIV: begin
                div_req.start    = 1'b1;
                div_req.dividend = mul_p[35:0] + 36'(term_den[16:1]);
                div_req.divisor  = 32'(term_den);
            end
            S_DDIV: begin
                div_req.start    = 1'b1;
                div_req.dividend = mul_p[35:0] + 36'(mag_den[22:1]);
                div_req.divisor  = 32'(mag_den);
            end
            S_CDIV: begin
                div_req.start    = 1'b1;
                div_req.dividend = mul_p[35:0];
                div_req.divisor  = rate_mag;
            end
            S_RDIV: begin
                div_req.start    = 1'b1;
                div_req.dividend = mul_p[35:0] + 36'(dt[31:1]);
                div_req.divisor  = dt;
            end
            default: begin
                div_req.start = 1'b0;
            end
        endcase
    end

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_beat) begin
                    state_next = s_tdata[STATUS_BUSY_BIT] ? S_FIN : S_HUM;
                end
            end
            S_HUM:   state_next = S_TMP;
            S_TMP:   state_next = S_TFIX;
            S_TFIX:  state_next = S_LSQ;
            S_LSQ:   state_next = S_LNORM;
            S_LNORM: state_next = (bit_reg == 4'd0) ? S_LLN : S_LSQ;
            S_LLN:   state_next = S_LRES;
            S_LRES:  state_next = pass_reg ? S_TDIV : S_LSQ;
            S_TDIV:  state_next = S_TWAIT;
            S_TWAIT: begin
                if (div_rsp.done) begin
                    state_next = S_AMUL;
                end
            end
            S_AMUL:  state_next = S_DDIV;
            S_DDIV:  state_next = S_DWAIT;
            S_DWAIT: begin
                if (div_rsp.done) begin
                    state_next = (spread_w >= 17'sd200 && rate_reg[31]) ? S_CMUL : S_RMUL;
                end
            end
            S_CMUL:  state_next = S_CDIV;
            S_CDIV:  state_next = S_CWAIT;
            S_CWAIT: begin
                if (div_rsp.done) begin
                    state_next = S_RMUL;
                end
            end
            S_RMUL:  state_next = (have_reg && dt >= RATE_MIN_DT) ? S_RDIV : S_FIN;
            S_RDIV:  state_next = S_RWAIT;
            S_RWAIT: begin
                if (div_rsp.done) begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Datapath registers stepped by the sequencer.
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            S_IDLE: begin
                if (s_beat) begin
                    raw_h_reg      <= {s_tdata[15:8], s_tdata[23:16], s_tdata[31:28]};
                    raw_t_reg      <= {s_tdata[27:24], s_tdata[39:32], s_tdata[47:40]};
                    now_reg        <= s_tdata[79:48];
                    busy_frame_reg <= s_tdata[STATUS_BUSY_BIT];
                end
            end
            S_TMP: begin
                hum_reg <= round_sum[33:20];
            end
            S_TFIX: begin
                temp_reg    <= t_clamp;
                m_reg       <= log_m;
                lg_int_reg  <= log_k;
                lg_frac_reg <= '0;
                bit_reg     <= 4'd15;
                pass_reg    <= 1'b0;
            end
            S_LNORM: begin
                if (sq[31]) begin
                    m_reg                <= {1'b0, sq[31:1]};
                    lg_frac_reg[bit_reg] <= 1'b1;
                end else begin
                    m_reg <= sq;
                end
                bit_reg <= bit_reg - 4'd1;
            end
            S_LRES: begin
                if (!pass_reg) begin
                    ln_h_reg    <= ln_w;
                    m_reg       <= log_m;
                    lg_int_reg  <= log_k;
                    lg_frac_reg <= '0;
                    bit_reg     <= 4'd15;
                    pass_reg    <= 1'b1;
                end else begin
                    ln_ref_reg <= ln_w;
                end
            end
            S_TWAIT: begin
                if (div_rsp.done) begin
                    alpha_reg <= term_s + ln_diff;
                end
            end
            S_DWAIT: begin
                if (div_rsp.done) begin
                    dew_reg    <= dew_w;
                    spread_reg <= spread_w;
                    if (spread_w < 17'sd200) begin
                        cd_reg <= 17'sd0;
                    end else begin
                        cd_reg <= -17'sd1;
                    end
                end
            end
            S_CWAIT: begin
                if (div_rsp.done) begin
                    cd_reg <= (div_rsp.quotient > 36'd65535) ? 17'sd65535
                                                            : $signed({1'b0, div_rsp.quotient[15:0]});
                end
            end
            default: begin
            end
        endcase
    end

    // Cooling-rate history; the countdown above has already used the old rate.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_reg      <= 1'b0;
            last_temp_reg <= '0;
            last_time_reg <= '0;
            rate_reg      <= '0;
        end else if (state_reg == S_RMUL && !have_reg) begin
            have_reg      <= 1'b1;
            last_temp_reg <= temp_reg;
            last_time_reg <= now_reg;
        end else if (state_reg == S_RWAIT && div_rsp.done) begin
            rate_reg      <= diff[15] ? -$signed(div_rsp.quotient[31:0])
                                      : $signed(div_rsp.quotient[31:0]);
            last_temp_reg <= temp_reg;
            last_time_reg <= now_reg;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (state_reg == S_FIN && out_free) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_FIN && out_free) begin
            if (busy_frame_reg) begin
                out_data_reg <= '0;
                out_user_reg <= 1'b0;
            end else begin
                out_data_reg <= {2'b00, cd_reg, spread_reg < 17'sd200, dew_reg,
                                 hum_reg, temp_reg};
                out_user_reg <= 1'b1;
            end
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    // Configuration: one register at byte address 0.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg <= '0;
        end else if (psel && penable && pwrite && pready && !paddr[2]) begin
            offset_reg <= $signed(pwdata[10:0]);
        end
    end

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {{21{offset_reg[10]}}, offset_reg};

endmodule

>>> hdl/hsdm_chk.sv
// ---------------------------------------------------------------------------
// Dew monitor port checker
// Port-level assertions, bound to the core.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "humidity_sensor_dew_monitor_core_macros.svh"

module hsdm_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic        m_tuser
);

    // Reset leaves an empty output and an idle input side.
    `HSDM_ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> (!m_tvalid && s_tready), "reset state wrong")

    // A frame keeps the core busy for at least the following cycle.
    `HSDM_ASSERT(a_busy_after_beat, aclk, aresetn, (s_tvalid && s_tready) |=> !s_tready, "ready after beat")

    // A refused frame yields an all-zero beat.
    `HSDM_ASSERT(a_refused_zero, aclk, aresetn, (m_tvalid && !m_tuser) |-> (m_tdata == 64'd0), "refused beat not zero")

    // A stalled result holds.
    `HSDM_ASSERT(a_out_hold, aclk, aresetn, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)), "stalled beat changed")

endmodule

bind humidity_sensor_dew_monitor_core hsdm_chk u_hsdm_chk (.*);
